// ----- rtl/kls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

  localparam int MAX_K  = 16;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = $clog2(MAX_K + 1);
  localparam int IDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [CFG_W-1:0]         kcfg_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    data_t value;
    logic  open;
  } link_t;

  // Rank as used by the chain: zero reads as one, large values saturate.
  function automatic count_t clamp_k(input kcfg_t k);
    logic [KCMP_W-1:0] kw;
    count_t            res;
    kw = KCMP_W'(k);
    if (kw == '0) begin
      res = count_t'(1);
    end else if (kw > KCMP_W'(MAX_K)) begin
      res = count_t'(MAX_K);
    end else begin
      res = count_t'(kw);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kls_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kls_cell (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire kls_pkg::data_t din,
  input  wire logic           in_range,
  input  wire kls_pkg::link_t left,
  output kls_pkg::link_t      right
);
  import kls_pkg::*;

  data_t val;
  logic  open;

  // A cell is open when the new word belongs here or further left; the open
  // cells always form a tail of the chain because the chain is sorted.
  assign open        = !in_range || (din > val);
  assign right.value = val;
  assign right.open  = open;

  always_ff @(posedge clk) begin
    if (load && open) begin
      val <= left.open ? left.value : din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kth_largest_selector.sv -----
// kth_largest_selector: k-th largest value of a stream of signed sets.
//
// Input channel: value and last, qualified by item_valid and item_stall.
// A word is taken at a rising edge with item_valid high and item_stall low.
// Output channel: kth_value and short_set, qualified by result_valid and
// result_stall. One result word leaves for every input word marked last.
// Register k_reg is loaded from k_select through k_select_wr; write it only
// while the block is idle, which the block itself does not enforce.
// A row of MAX_K cells holds the largest values seen so far, sorted from
// largest to smallest; every cell compares the incoming word in parallel
// and takes either it or its left neighbor, so words are taken back to back.
// After the word marked last, item_stall is high until the result is
// copied from the chain into the output register. The last word sets
// emit_pending, and that copy then sets result_valid. If result_stall holds
// the previous result, the next set end waits, and input stalls until the
// register frees. Synchronous reset empties the chain, drops any result and
// sets k to 1.
`timescale 1ns / 1ps
`default_nettype none

module kth_largest_selector (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            k_select_wr,
  input  wire kls_pkg::kcfg_t  k_select,
  input  wire kls_pkg::data_t  value,
  input  wire logic            last,
  input  wire logic            item_valid,
  output logic                 item_stall,
  output kls_pkg::data_t       kth_value,
  output logic                 short_set,
  output logic                 result_valid,
  input  wire logic            result_stall
);
  import kls_pkg::*;

  kcfg_t  k_reg;
  count_t count;
  count_t count_next;
  count_t k_eff;
  count_t n;
  count_t count_m1;
  logic   emit_pending;
  logic   accept;
  logic   emit;
  logic   drop;
  logic   any_open;

  link_t           links [MAX_K+1];
  logic [MAX_K-1:0] in_range;
  logic [MAX_K-1:0] open_vec;
  data_t           cell_val [MAX_K];

  assign k_eff      = clamp_k(k_reg);
  assign n          = (count > k_eff) ? k_eff : count;
  assign item_stall = emit_pending;
  assign accept     = item_valid && !item_stall;
  assign emit       = emit_pending && (!result_valid || !result_stall);

  assign links[0].value = '0;
  assign links[0].open  = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_K; gi++) begin : g_cell
      assign in_range[gi] = count_t'(gi) < n;
      assign open_vec[gi] = links[gi+1].open;
      assign cell_val[gi] = links[gi+1].value;

      kls_cell u_cell (
        .clk      (clk),
        .load     (accept && !drop),
        .din      (value),
        .in_range (in_range[gi]),
        .left     (links[gi]),
        .right    (links[gi+1])
      );
    end
  endgenerate

  // A full chain with no smaller kept value has no place for the new word.
  assign any_open = |(open_vec & in_range);
  assign drop     = (n == k_eff) && !any_open;

  always_comb begin
    if (drop) begin
      count_next = n;
    end else if (n < k_eff) begin
      count_next = n + count_t'(1);
    end else begin
      count_next = k_eff;
    end
  end

  assign count_m1 = count - count_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg        <= kcfg_t'(1);
      count        <= '0;
      emit_pending <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (k_select_wr) begin
        k_reg <= k_select;
      end
      if (emit) begin
        count        <= '0;
        emit_pending <= 1'b0;
        result_valid <= 1'b1;
      end else begin
        if (accept) begin
          count        <= count_next;
          emit_pending <= last;
        end
        if (result_valid && !result_stall) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kth_value <= cell_val[count_m1[IDX_W-1:0]];
      short_set <= count < k_eff;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(MAX_K))
    else $error("kept count exceeds chain depth");

  a_last_pends : assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (emit_pending && count != '0))
    else $error("set end did not leave a pending result");

  a_emit_loads : assert property (@(posedge clk) disable iff (rst)
    $fell(emit_pending) |-> (result_valid && count == '0))
    else $error("pending result was not delivered to the output");

  generate
    for (gi = 0; gi + 1 < MAX_K; gi++) begin : g_sorted
      a_sorted : assert property (@(posedge clk) disable iff (rst)
        (count_t'(gi + 1) < count) |-> (cell_val[gi] >= cell_val[gi+1]))
        else $error("kept values out of order");
    end
  endgenerate
`endif

endmodule

`default_nettype wire

// ----- verif/kth_select_checker.sv -----
`timescale 1ns / 1ps

module kth_select_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           k_select_wr,
  input  kls_pkg::kcfg_t k_select,
  input  kls_pkg::data_t value,
  input  logic           last,
  input  logic           item_valid,
  input  logic           item_stall,
  input  kls_pkg::data_t kth_value,
  input  logic           short_set,
  input  logic           result_valid,
  input  logic           result_stall,
  output int             mismatches,
  output int             words_pending
);
  import kls_pkg::*;

  typedef struct {
    data_t kth;
    logic  short_flag;
  } kth_result_t;

  kcfg_t       rank_reg;
  data_t       chain[MAX_K];
  int          kept;
  int          errs;
  kth_result_t expected_kth[$];

  function automatic int rank_in_use(input kcfg_t k);
    int r;
    r = int'(k);
    if (r == 0) begin
      r = 1;
    end else if (r > MAX_K) begin
      r = MAX_K;
    end
    return r;
  endfunction

  // Keeps the chain sorted from largest to smallest, at most k entries deep.
  task automatic insert_word(input data_t v, input int k);
    int n;
    int pos;
    int hi;
    n = (kept > k) ? k : kept;
    pos = 0;
    while (pos < n && chain[pos] >= v) pos++;
    if (pos >= k) begin
      kept = n;
      return;
    end
    hi = (n < k) ? n : k - 1;
    for (int j = hi; j > pos; j--) chain[j] = chain[j - 1];
    chain[pos] = v;
    kept = (n < k) ? n + 1 : k;
  endtask

  always @(posedge clk) begin
    int          k;
    int          idx;
    kth_result_t want;
    kth_result_t got;
    if (rst) begin
      rank_reg = kcfg_t'(1);
      kept = 0;
      errs = 0;
      expected_kth.delete();
    end else begin
      // A word taken at this edge still sees the rank from before any write.
      if (item_valid && !item_stall) begin
        k = rank_in_use(rank_reg);
        insert_word(value, k);
        if (last) begin
          idx = (kept == 0) ? 0 : kept - 1;
          want.kth = chain[idx];
          want.short_flag = (kept < k);
          expected_kth.insert(expected_kth.size(), want);
          kept = 0;
        end
      end
      if (k_select_wr) begin
        rank_reg = k_select;
      end
      if (result_valid && !result_stall) begin
        got.kth = kth_value;
        got.short_flag = short_set;
        if (expected_kth.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got kth_value %0d short_set %0b",
                   $time, got.kth, got.short_flag);
          errs++;
        end else begin
          want = expected_kth.pop_front();
          if (got.kth !== want.kth) begin
            $display("%0t: kth_value mismatch, expected %0d, got %0d",
                     $time, want.kth, got.kth);
            errs++;
          end
          if (got.short_flag !== want.short_flag) begin
            $display("%0t: short_set mismatch, expected %0b, got %0b",
                     $time, want.short_flag, got.short_flag);
            errs++;
          end
        end
      end
    end
    mismatches <= errs;
    words_pending <= expected_kth.size();
  end

endmodule

// ----- verif/tb_kth_largest_selector.sv -----
`timescale 1ns / 1ps

module tb_kth_largest_selector;
  import kls_pkg::*;

  localparam data_t DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam data_t DATA_MAX = ~DATA_MIN;

  logic  clk;
  logic  rst = 1'b1;
  logic  k_select_wr = 1'b0;
  kcfg_t k_select = '0;
  data_t value = '0;
  logic  last = 1'b0;
  logic  item_valid = 1'b0;
  logic  item_stall;
  data_t kth_value;
  logic  short_set;
  logic  result_valid;
  logic  result_stall = 1'b0;

  int mismatches;
  int words_pending;
  int send_idle = 15;
  int recv_idle = 49;
  int hold_cycles = 0;
  int words_sent = 0;
  bit held = 1'b0;

  kth_largest_selector dut (
    .clk          (clk),
    .rst          (rst),
    .k_select_wr  (k_select_wr),
    .k_select     (k_select),
    .value        (value),
    .last         (last),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kth_value    (kth_value),
    .short_set    (short_set),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  kth_select_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .k_select_wr   (k_select_wr),
    .k_select      (k_select),
    .value         (value),
    .last          (last),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kth_value     (kth_value),
    .short_set     (short_set),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_word(input data_t v, input logic l);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value <= v;
    last <= l;
    do @(posedge clk); while (item_stall);
  endtask

  // The first edge lets the count of pending results catch up with the last word.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rank(input kcfg_t k);
    wait_drained();
    k_select_wr <= 1'b1;
    k_select <= k;
    @(posedge clk);
    k_select_wr <= 1'b0;
  endtask

  function automatic data_t rand_value();
    data_t v;
    case ($urandom_range(9))
      0:       v = DATA_MIN;
      1:       v = DATA_MAX;
      2:       v = '0;
      3:       v = '1;
      4, 5:    v = data_t'($signed($urandom_range(15)) - 8);
      default: v = data_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic kcfg_t pick_rank();
    kcfg_t k;
    case ($urandom_range(6))
      0:       k = kcfg_t'(0);
      1:       k = kcfg_t'(1);
      2:       k = kcfg_t'(MAX_K);
      3:       k = kcfg_t'($urandom_range(31, MAX_K + 1));
      4:       k = kcfg_t'(2);
      default: k = kcfg_t'($urandom_range(MAX_K, 1));
    endcase
    return k;
  endfunction

  task automatic random_set(input int max_len);
    int len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(24, 17);
    end else begin
      len = $urandom_range(max_len, 1);
    end
    if ($urandom_range(4) == 0) begin
      set_rank(pick_rank());
    end
    for (int i = 0; i < len; i++) begin
      if (i == len / 2 && i > 0 && $urandom_range(9) == 0) begin
        set_rank(pick_rank());
      end
      send_word(rand_value(), (i == len - 1));
      words_sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Rank one after reset, with the extreme values.
    send_word(DATA_MIN, 1'b1);
    send_word(DATA_MAX, 1'b1);
    // A rank of zero behaves as rank one.
    set_rank(kcfg_t'(0));
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b1);
    // A rank above the chain depth saturates, and this set is short.
    set_rank(kcfg_t'(31));
    send_word(data_t'(7), 1'b0);
    send_word(DATA_MIN, 1'b0);
    send_word(DATA_MAX, 1'b0);
    send_word(data_t'(7), 1'b1);
    // Equal values count as separate elements.
    set_rank(kcfg_t'(3));
    send_word(data_t'(5), 1'b0);
    send_word(data_t'(5), 1'b0);
    send_word(data_t'(5), 1'b0);
    send_word(data_t'(-2), 1'b1);
    // Rank lowered in the middle of a set.
    set_rank(kcfg_t'(4));
    send_word(data_t'(9), 1'b0);
    send_word(data_t'(3), 1'b0);
    send_word(data_t'(6), 1'b0);
    set_rank(kcfg_t'(2));
    send_word(data_t'(1), 1'b0);
    send_word(data_t'(2), 1'b1);
    // Rank raised in the middle of a set: dropped values stay lost.
    set_rank(kcfg_t'(2));
    send_word(data_t'(8), 1'b0);
    send_word(data_t'(4), 1'b0);
    send_word(data_t'(6), 1'b0);
    set_rank(kcfg_t'(5));
    send_word(data_t'(1), 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 15;
          recv_idle = 49;
        end
        1: begin
          send_idle = 49;
          recv_idle = 15;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      while (words_sent < 270 * (phase + 1)) begin
        if (phase == 0 && !held && words_sent >= 100) begin
          // Short sets keep arriving while results are held back.
          hold_cycles = 400;
          repeat (20) random_set(2);
          held = 1'b1;
        end
        random_set(12);
      end
      wait_drained();
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- kth_largest_selector.f -----
rtl/kls_pkg.sv
rtl/kls_cell.sv
rtl/kth_largest_selector.sv
verif/kth_select_checker.sv
verif/tb_kth_largest_selector.sv
